/* rtl/erdm_pkg.sv */
// Shared constants, types and landmark pair tables for the eye ratio monitor.
package erdm_pkg;

   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 8;
   localparam int SLOT_BITS    = 5;
   localparam int NUM_SLOTS    = 17;
   localparam int ADDR_BITS    = $clog2(NUM_SLOTS);
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * COORD_BITS;
   localparam int SQ_BITS      = 2 * COORD_BITS + 1;
   localparam int RAD_BITS     = SQ_BITS + 2 * FRAC_BITS;
   localparam int ROOT_BITS    = (RAD_BITS + 1) / 2;
   localparam int NUM_BITS     = ROOT_BITS + 1 + FRAC_BITS;
   localparam int DEN_BITS     = ROOT_BITS + 1;
   localparam int CNT_BITS     = 10;
   localparam int THR_BITS     = 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int OP_BITS      = 4;

   localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(NUM_SLOTS - 1);
   localparam logic [CNT_BITS-1:0]  CNT_MAX   = '1;

   localparam logic [CSR_IDX_BITS-1:0] REG_EAR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ALERT_FRAMES  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_WARN_FRAMES   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECORD_LENGTH = 2'd3;

   localparam logic [OP_BITS-1:0] OP_L_A   = 4'd0;
   localparam logic [OP_BITS-1:0] OP_L_B   = 4'd1;
   localparam logic [OP_BITS-1:0] OP_L_C   = 4'd2;
   localparam logic [OP_BITS-1:0] OP_R_A   = 4'd3;
   localparam logic [OP_BITS-1:0] OP_R_B   = 4'd4;
   localparam logic [OP_BITS-1:0] OP_R_C   = 4'd5;
   localparam logic [OP_BITS-1:0] OP_WIDTH = 4'd6;
   localparam logic [OP_BITS-1:0] OP_HIGHT = 4'd7;
   localparam logic [OP_BITS-1:0] OP_NOSE  = 4'd8;
   localparam logic [OP_BITS-1:0] OP_L_CTR = 4'd9;
   localparam logic [OP_BITS-1:0] OP_R_CTR = 4'd10;

   typedef struct packed {
      logic [ADDR_BITS-1:0]         slot;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic [THR_BITS-1:0] ear_threshold;
      logic [CNT_BITS-1:0] alert_frames;
      logic [CNT_BITS-1:0] warn_frames;
      logic [CNT_BITS-1:0] record_length;
   } cfg_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] mean_ratio;
      logic                drowsy_alert;
      logic                distraction_alert;
      logic                frame_recorded;
      logic                drowsy_warning;
      logic                distraction_warning;
   } result_type;

   function automatic logic [ADDR_BITS-1:0] op_addr_a(input logic [OP_BITS-1:0] op);
      logic [ADDR_BITS-1:0] a;
      case (op)
         OP_L_A:   a = 5'd1;
         OP_L_B:   a = 5'd2;
         OP_L_C:   a = 5'd0;
         OP_R_A:   a = 5'd7;
         OP_R_B:   a = 5'd8;
         OP_R_C:   a = 5'd6;
         OP_WIDTH: a = 5'd12;
         OP_HIGHT: a = 5'd15;
         OP_NOSE:  a = 5'd14;
         OP_L_CTR: a = 5'd0;
         OP_R_CTR: a = 5'd6;
         default:  a = 5'd0;
      endcase
      return a;
   endfunction

   function automatic logic [ADDR_BITS-1:0] op_addr_b(input logic [OP_BITS-1:0] op);
      logic [ADDR_BITS-1:0] b;
      case (op)
         OP_L_A:   b = 5'd5;
         OP_L_B:   b = 5'd4;
         OP_L_C:   b = 5'd3;
         OP_R_A:   b = 5'd11;
         OP_R_B:   b = 5'd10;
         OP_R_C:   b = 5'd9;
         OP_WIDTH: b = 5'd13;
         OP_HIGHT: b = 5'd16;
         OP_NOSE:  b = 5'd14;
         OP_L_CTR: b = 5'd3;
         OP_R_CTR: b = 5'd9;
         default:  b = 5'd0;
      endcase
      return b;
   endfunction

endpackage

/* rtl/eye_ratio_drowsiness_monitor.sv */
// Top level of the eye ratio drowsiness and distraction monitor.
//   channel   handshake            word
//   req       req_valid/req_ready  point_index, x_coord, y_coord
//   rsp       rsp_valid/rsp_ready  mean_ratio and five flags, one per face
//   csr       csr_valid/csr_ready  csr_index, csr_data
// A point is stored as it is popped; the last point of a face starts the pop, eleven
// operand steps, six square roots, up to two divides and the load.
// No new point is popped until the face's result is loaded.
// Reset is synchronous; no clearing pass, a slot not sent for a face keeps its last value.
// A stalled result holds in its register; a two-word queue takes points while a face is in progress.
module eye_ratio_drowsiness_monitor import erdm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SLOT_BITS-1:0]         req_point_index,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [CNT_BITS-1:0]          rsp_mean_ratio,
   output logic                         rsp_drowsy_alert,
   output logic                         rsp_distraction_alert,
   output logic                         rsp_frame_recorded,
   output logic                         rsp_drowsy_warning,
   output logic                         rsp_distraction_warning,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CNT_BITS-1:0]          csr_data
);

   cfg_type    cfg_ff;
   logic       pop_valid, pop_ready;
   point_type  pop_point;
   result_type rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ear_threshold <= 8'd64;
         cfg_ff.alert_frames  <= 10'd90;
         cfg_ff.warn_frames   <= 10'd45;
         cfg_ff.record_length <= 10'd750;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_EAR_THRESHOLD: cfg_ff.ear_threshold <= csr_data[THR_BITS-1:0];
            REG_ALERT_FRAMES:  cfg_ff.alert_frames  <= csr_data;
            REG_WARN_FRAMES:   cfg_ff.warn_frames   <= csr_data;
            REG_RECORD_LENGTH: cfg_ff.record_length <= csr_data;
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   erdm_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_index(req_point_index), .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_point(pop_point)
   );

   erdm_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_point(pop_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   assign rsp_mean_ratio          = rsp_word.mean_ratio;
   assign rsp_drowsy_alert        = rsp_word.drowsy_alert;
   assign rsp_distraction_alert   = rsp_word.distraction_alert;
   assign rsp_frame_recorded      = rsp_word.frame_recorded;
   assign rsp_drowsy_warning      = rsp_word.drowsy_warning;
   assign rsp_distraction_warning = rsp_word.distraction_warning;

endmodule

/* rtl/erdm_front.sv */
// Input side: accepts landmark words, drops bad slots and queues the rest.
module erdm_front import erdm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SLOT_BITS-1:0]         req_point_index,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   output logic                         pop_valid,
   input  logic                         pop_ready,
   output point_type                    pop_point
);

   point_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop, keep;

   assign req_ready = (count_ff != 2'd2);
   assign keep      = (req_point_index <= SLOT_BITS'(LAST_SLOT));
   assign push      = req_valid && req_ready && keep;
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_point = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{slot: req_point_index[ADDR_BITS-1:0],
                                  x: req_x_coord, y: req_y_coord};
      end
   end

endmodule

/* rtl/erdm_isqrt.sv */
// Integer square root, one root bit per cycle.
module erdm_isqrt import erdm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_BITS-1:0]  radicand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);

   localparam int PAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int TMP_BITS = REM_BITS + 2;
   localparam int CNT_W    = $clog2(ROOT_BITS + 1);

   logic [PAD_BITS-1:0]  rad_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff, done_ff;
   logic [TMP_BITS-1:0]  rem_t, trial;
   logic                 fit;

   assign rem_t = {rem_ff, rad_ff[PAD_BITS-1 -: 2]};
   assign trial = TMP_BITS'({root_ff, 2'b01});
   assign fit   = (rem_t >= trial);
   assign done  = done_ff;
   assign root  = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(ROOT_BITS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= PAD_BITS'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fit ? REM_BITS'(rem_t - trial) : REM_BITS'(rem_t);
         root_ff <= {root_ff[ROOT_BITS-2:0], fit};
      end
   end

endmodule

/* rtl/erdm_div.sv */
// Restoring divider, one quotient bit per cycle.
module erdm_div import erdm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);

   localparam int REM_BITS = DEN_BITS + 1;
   localparam int CNT_W    = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [REM_BITS-1:0] rem_ff, rem_t, den_x;
   logic [CNT_W-1:0]    cnt_ff;
   logic                run_ff, done_ff, fit;

   assign rem_t = {rem_ff[REM_BITS-2:0], num_ff[NUM_BITS-1]};
   assign den_x = {1'b0, den_ff};
   assign fit   = (rem_t >= den_x);
   assign done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_BITS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         den_ff <= denom;
         rem_ff <= '0;
         quot   <= '0;
      end else if (run_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= fit ? (rem_t - den_x) : rem_t;
         quot   <= {quot[NUM_BITS-2:0], fit};
      end
   end

endmodule

/* rtl/erdm_back.sv */
// Work side: point store, per-face sequencer, counters and result register.
module erdm_back import erdm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  point_type  pop_point,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_word
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_USE  = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   localparam int CMP_BITS = NUM_BITS + 2 * THR_BITS + 2 * FRAC_BITS;

   logic [2*COORD_BITS-1:0] mem [NUM_SLOTS];
   logic [2*COORD_BITS-1:0] qa_ff, qb_ff;
   logic [2:0]              state_ff;
   logic [OP_BITS-1:0]      op_ff;
   logic [PROD_BITS-1:0]    sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [SQ_BITS-1:0]      wsq_ff, hsq_ff, sum;
   logic signed [DIFF_BITS-1:0] nose_x_ff, nose_y_ff;
   logic [ROOT_BITS-1:0]    dist_a_ff, dist_b_ff;
   logic [NUM_BITS-1:0]     ratio_l_ff, ratio_r_ff;
   logic                    sat_l_ff, sat_r_ff, on_road_ff;
   logic [CNT_BITS-1:0]     dcnt_ff, xcnt_ff, rcnt_ff;
   logic                    active_ff;
   logic                    rsp_valid_ff;
   result_type              rsp_ff;

   logic pop, sq_start, sq_done, dv_start, dv_done, c_op, ctr_op, last_op, load;
   logic [ROOT_BITS-1:0] root;
   logic [NUM_BITS-1:0]  quot, numer;
   logic [DEN_BITS-1:0]  denom;
   logic [RAD_BITS-1:0]  radicand;
   logic signed [DIFF_BITS-1:0] xa, ya, xb, yb, sx, sy, ex, ey, dx, dy;
   logic signed [2*DIFF_BITS-1:0] px, py;

   assign pop_ready = (state_ff == S_IDLE);
   assign pop       = pop_valid && pop_ready;
   assign c_op      = (op_ff == OP_L_C) || (op_ff == OP_R_C);
   assign ctr_op    = (op_ff == OP_L_CTR) || (op_ff == OP_R_CTR);
   assign last_op   = (op_ff == OP_R_CTR);
   assign load      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (pop) begin
         mem[pop_point.slot] <= {pop_point.x, pop_point.y};
      end
      qa_ff <= mem[op_addr_a(op_ff)];
      qb_ff <= mem[op_addr_b(op_ff)];
   end

   always_comb begin
      xa = DIFF_BITS'($signed(qa_ff[2*COORD_BITS-1:COORD_BITS]));
      ya = DIFF_BITS'($signed(qa_ff[COORD_BITS-1:0]));
      xb = DIFF_BITS'($signed(qb_ff[2*COORD_BITS-1:COORD_BITS]));
      yb = DIFF_BITS'($signed(qb_ff[COORD_BITS-1:0]));
      sx = xa + xb;
      sy = ya + yb;
      ex = (sx + $signed(DIFF_BITS'(sx[DIFF_BITS-1]))) >>> 1;
      ey = (sy + $signed(DIFF_BITS'(sy[DIFF_BITS-1]))) >>> 1;
      dx = ctr_op ? (nose_x_ff - ex) : (xa - xb);
      dy = ctr_op ? (nose_y_ff - ey) : (ya - yb);
      px = dx * dx;
      py = dy * dy;
      sqx_in = px[PROD_BITS-1:0];
      sqy_in = py[PROD_BITS-1:0];
      sum    = SQ_BITS'(sqx_ff) + SQ_BITS'(sqy_ff);
      radicand = {sum, {(2*FRAC_BITS){1'b0}}};
      numer = {(DEN_BITS'(dist_a_ff) + DEN_BITS'(dist_b_ff)), {FRAC_BITS{1'b0}}};
      denom = {root, 1'b0};
   end

   assign sq_start = (state_ff == S_USE) && (op_ff <= OP_R_C);
   assign dv_start = (state_ff == S_SQRT) && sq_done && c_op && (root != '0);

   erdm_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(radicand),
      .done(sq_done), .root(root)
   );

   erdm_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .numer(numer),
      .denom(denom), .done(dv_done), .quot(quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_L_A;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (pop && (pop_point.slot == LAST_SLOT)) begin
                  state_ff <= S_RD;
                  op_ff    <= OP_L_A;
               end
            end
            S_RD:   state_ff <= S_CALC;
            S_CALC: state_ff <= S_USE;
            S_USE: begin
               if (sq_start) begin
                  state_ff <= S_SQRT;
               end else if (last_op) begin
                  state_ff <= S_FIN;
               end else begin
                  op_ff    <= op_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_SQRT: begin
               if (sq_done) begin
                  if (dv_start) begin
                     state_ff <= S_DIV;
                  end else begin
                     op_ff    <= op_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end
            end
            S_DIV: begin
               if (dv_done) begin
                  op_ff    <= op_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_FIN: begin
               if (load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         if (op_ff == OP_NOSE) begin
            nose_x_ff <= xa;
            nose_y_ff <= ya;
         end
      end
      if (state_ff == S_USE) begin
         if (op_ff == OP_WIDTH) wsq_ff <= sum;
         if (op_ff == OP_HIGHT) hsq_ff <= sum;
         if (op_ff == OP_L_CTR) begin
            on_road_ff <= ((PROD_BITS+4)'({sqx_ff, 4'b0}) < (PROD_BITS+4)'(wsq_ff)) &&
                          ((PROD_BITS+4)'({sqy_ff, 4'b0}) < (PROD_BITS+4)'(hsq_ff));
         end
         if (op_ff == OP_R_CTR) begin
            on_road_ff <= on_road_ff &&
                          ((PROD_BITS+4)'({sqx_ff, 4'b0}) < (PROD_BITS+4)'(wsq_ff)) &&
                          ((PROD_BITS+4)'({sqy_ff, 4'b0}) < (PROD_BITS+4)'(hsq_ff));
         end
      end
      if ((state_ff == S_SQRT) && sq_done) begin
         if ((op_ff == OP_L_A) || (op_ff == OP_R_A)) dist_a_ff <= root;
         if ((op_ff == OP_L_B) || (op_ff == OP_R_B)) dist_b_ff <= root;
         if (op_ff == OP_L_C) sat_l_ff <= (root == '0);
         if (op_ff == OP_R_C) sat_r_ff <= (root == '0);
      end
      if ((state_ff == S_DIV) && dv_done) begin
         if (op_ff == OP_L_C) ratio_l_ff <= quot;
         if (op_ff == OP_R_C) ratio_r_ff <= quot;
      end
   end

   logic                sat;
   logic [NUM_BITS-1:0] mean;
   logic [CMP_BITS-1:0] mean_cmp, thr_cmp;
   logic                closed, d_alert, x_alert;
   logic [CNT_BITS-1:0] dc1, dc_in, xc1, xc_in, rc1, rc_in, rc_inc;
   logic                act1, active_in;
   result_type          res;

   always_comb begin
      sat      = sat_l_ff || sat_r_ff;
      mean     = NUM_BITS'(((NUM_BITS+1)'(ratio_l_ff) + (NUM_BITS+1)'(ratio_r_ff)) >> 1);
      mean_cmp = CMP_BITS'({mean, {THR_BITS{1'b0}}});
      thr_cmp  = CMP_BITS'({cfg.ear_threshold, {FRAC_BITS{1'b0}}});
      closed   = !sat && (mean_cmp < thr_cmp);
      dc1      = closed ? ((dcnt_ff == CNT_MAX) ? dcnt_ff : dcnt_ff + 1'b1) : '0;
      d_alert  = (dc1 >= cfg.alert_frames);
      dc_in    = d_alert ? '0 : dc1;
      xc1      = !on_road_ff ? ((xcnt_ff == CNT_MAX) ? xcnt_ff : xcnt_ff + 1'b1) : '0;
      x_alert  = (xc1 >= cfg.alert_frames);
      xc_in    = x_alert ? '0 : xc1;
      act1     = active_ff || d_alert || x_alert;
      rc1      = (!active_ff && (d_alert || x_alert)) ? '0 : rcnt_ff;
      rc_inc   = rc1 + 1'b1;
      rc_in    = act1 ? rc_inc : rc1;
      active_in = act1 && !(rc_inc == cfg.record_length);
      if (sat || (mean > NUM_BITS'(CNT_MAX))) begin
         res.mean_ratio = CNT_MAX;
      end else begin
         res.mean_ratio = mean[CNT_BITS-1:0];
      end
      res.drowsy_alert        = d_alert;
      res.distraction_alert   = x_alert;
      res.frame_recorded      = act1;
      res.drowsy_warning      = act1 && (dc_in >= cfg.warn_frames);
      res.distraction_warning = act1 && (xc_in >= cfg.warn_frames);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff      <= '0;
         xcnt_ff      <= '0;
         rcnt_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            dcnt_ff      <= dc_in;
            xcnt_ff      <= xc_in;
            rcnt_ff      <= rc_in;
            active_ff    <= active_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE))
      else $error("point popped while a face is in progress");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("result load did not return to idle");

   a_alert_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.drowsy_alert || rsp_ff.distraction_alert)
         |-> rsp_ff.frame_recorded)
      else $error("alert without an open recording window");

   a_div_after_sqrt: assert property (@(posedge clock) disable iff (reset)
      dv_start |-> c_op && (state_ff == S_SQRT))
      else $error("divide started outside eye width step");

endmodule

/* bench/erdm_checker.sv */
// Checker for the eye ratio monitor: predicts each face result and compares it on the rsp channel.
`timescale 1ns / 1ps
module erdm_checker import erdm_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [SLOT_BITS-1:0]         req_point_index,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [CNT_BITS-1:0]          rsp_mean_ratio,
   input  logic                         rsp_drowsy_alert,
   input  logic                         rsp_distraction_alert,
   input  logic                         rsp_frame_recorded,
   input  logic                         rsp_drowsy_warning,
   input  logic                         rsp_distraction_warning,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CNT_BITS-1:0]          csr_data,
   output int                           fail_count,
   output int                           pending,
   output int                           faces_seen,
   output int                           alerts_seen
);

   localparam longint unsigned RATIO_SAT = 64'd1 << 44;

   int               px [NUM_SLOTS];
   int               py [NUM_SLOTS];
   cfg_type          cfg;
   logic [CNT_BITS-1:0] drowsy_cnt, distract_cnt, rec_cnt;
   logic             rec_on;
   result_type       face_q[$];

   function automatic longint unsigned root64(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned span_sq(input int a, input int b);
      longint dx, dy;
      dx = px[a] - px[b];
      dy = py[a] - py[b];
      return longint'(dx * dx + dy * dy);
   endfunction

   function automatic longint unsigned eye_ratio(input int b);
      longint unsigned ha, hb, wd;
      ha = root64(span_sq(b + 1, b + 5) << (2 * FRAC_BITS));
      hb = root64(span_sq(b + 2, b + 4) << (2 * FRAC_BITS));
      wd = root64(span_sq(b, b + 3) << (2 * FRAC_BITS));
      if (wd == 0) return RATIO_SAT;
      return ((ha + hb) << FRAC_BITS) / (2 * wd);
   endfunction

   function automatic bit eye_centered(input int b);
      longint ex, ey, dx, dy;
      ex = (px[b] + px[b + 3]) / 2;
      ey = (py[b] + py[b + 3]) / 2;
      dx = px[14] - ex;
      dy = py[14] - ey;
      return (longint'(16 * dx * dx) < longint'(span_sq(12, 13)))
          && (longint'(16 * dy * dy) < longint'(span_sq(15, 16)));
   endfunction

   task automatic open_record();
      if (!rec_on) begin
         rec_on  = 1'b1;
         rec_cnt = '0;
      end
   endtask

   task automatic predict_face();
      longint unsigned mean;
      result_type r;
      r    = '0;
      mean = (eye_ratio(0) + eye_ratio(6)) >> 1;
      r.mean_ratio = (mean > CNT_MAX) ? CNT_MAX : mean[CNT_BITS-1:0];
      if (mean < cfg.ear_threshold) begin
         if (drowsy_cnt != CNT_MAX) drowsy_cnt = drowsy_cnt + 1'b1;
      end else begin
         drowsy_cnt = '0;
      end
      if (drowsy_cnt >= cfg.alert_frames) begin
         r.drowsy_alert = 1'b1;
         drowsy_cnt = '0;
         open_record();
      end
      if (!(eye_centered(0) && eye_centered(6))) begin
         if (distract_cnt != CNT_MAX) distract_cnt = distract_cnt + 1'b1;
      end else begin
         distract_cnt = '0;
      end
      if (distract_cnt >= cfg.alert_frames) begin
         r.distraction_alert = 1'b1;
         distract_cnt = '0;
         open_record();
      end
      if (rec_on) begin
         r.frame_recorded      = 1'b1;
         r.drowsy_warning      = drowsy_cnt >= cfg.warn_frames;
         r.distraction_warning = distract_cnt >= cfg.warn_frames;
         rec_cnt = rec_cnt + 1'b1;
         if (rec_cnt == cfg.record_length) rec_on = 1'b0;
      end
      face_q = {face_q, r};
   endtask

   task automatic check_face();
      result_type e;
      if (face_q.size() == 0) begin
         $display("%0t: result with no face pending, mean_ratio %0d", $time, rsp_mean_ratio);
         fail_count = fail_count + 1;
         return;
      end
      e = face_q.pop_front();
      if (e.drowsy_alert || e.distraction_alert) alerts_seen = alerts_seen + 1;
      if (rsp_mean_ratio !== e.mean_ratio) begin
         $display("%0t: mean_ratio expected %0d actual %0d", $time, e.mean_ratio,
                  rsp_mean_ratio);
         fail_count = fail_count + 1;
      end
      if (rsp_drowsy_alert !== e.drowsy_alert) begin
         $display("%0t: drowsy_alert expected %0b actual %0b", $time, e.drowsy_alert,
                  rsp_drowsy_alert);
         fail_count = fail_count + 1;
      end
      if (rsp_distraction_alert !== e.distraction_alert) begin
         $display("%0t: distraction_alert expected %0b actual %0b", $time,
                  e.distraction_alert, rsp_distraction_alert);
         fail_count = fail_count + 1;
      end
      if (rsp_frame_recorded !== e.frame_recorded) begin
         $display("%0t: frame_recorded expected %0b actual %0b", $time, e.frame_recorded,
                  rsp_frame_recorded);
         fail_count = fail_count + 1;
      end
      if (rsp_drowsy_warning !== e.drowsy_warning) begin
         $display("%0t: drowsy_warning expected %0b actual %0b", $time, e.drowsy_warning,
                  rsp_drowsy_warning);
         fail_count = fail_count + 1;
      end
      if (rsp_distraction_warning !== e.distraction_warning) begin
         $display("%0t: distraction_warning expected %0b actual %0b", $time,
                  e.distraction_warning, rsp_distraction_warning);
         fail_count = fail_count + 1;
      end
   endtask

   initial begin
      fail_count  = 0;
      pending     = 0;
      faces_seen  = 0;
      alerts_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg.ear_threshold = 8'd64;
         cfg.alert_frames  = 10'd90;
         cfg.warn_frames   = 10'd45;
         cfg.record_length = 10'd750;
         drowsy_cnt   = '0;
         distract_cnt = '0;
         rec_cnt      = '0;
         rec_on       = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            px[i] = 0;
            py[i] = 0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_EAR_THRESHOLD: cfg.ear_threshold = csr_data[THR_BITS-1:0];
               REG_ALERT_FRAMES:  cfg.alert_frames  = csr_data;
               REG_WARN_FRAMES:   cfg.warn_frames   = csr_data;
               REG_RECORD_LENGTH: cfg.record_length = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            check_face();
            faces_seen = faces_seen + 1;
         end
         if (req_valid && req_ready && req_point_index < NUM_SLOTS) begin
            px[req_point_index] = req_x_coord;
            py[req_point_index] = req_y_coord;
            if (req_point_index == NUM_SLOTS - 1) predict_face();
         end
      end
      pending = face_q.size();
   end

endmodule

/* bench/tb_eye_ratio_drowsiness_monitor.sv */
// Testbench top for the eye ratio monitor: drives faces and settings, reports the verdict.
`timescale 1ns / 1ps
module tb_eye_ratio_drowsiness_monitor;
   import erdm_pkg::*;

   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN       = 300;
   localparam int NUM_PHASES  = 8;
   localparam int FACES_PHASE = 12;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [SLOT_BITS-1:0]         req_point_index = '0;
   logic signed [COORD_BITS-1:0] req_x_coord = '0;
   logic signed [COORD_BITS-1:0] req_y_coord = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [CNT_BITS-1:0]          rsp_mean_ratio;
   logic                         rsp_drowsy_alert, rsp_distraction_alert, rsp_frame_recorded;
   logic                         rsp_drowsy_warning, rsp_distraction_warning;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_BITS-1:0]      csr_index = '0;
   logic [CNT_BITS-1:0]          csr_data = '0;

   int fail_count, pending, faces_seen, alerts_seen;
   int idle_cycles = 0;
   int points_sent = 0;
   int stall_left  = 0;
   bit quiet       = 1'b0;
   int fx [NUM_SLOTS];
   int fy [NUM_SLOTS];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   eye_ratio_drowsiness_monitor DUT (.*);

   erdm_checker u_checker (.*);

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_point(input int idx, input int x, input int y);
      int g;
      req_valid       <= 1'b1;
      req_point_index <= idx[SLOT_BITS-1:0];
      req_x_coord     <= x[COORD_BITS-1:0];
      req_y_coord     <= y[COORD_BITS-1:0];
      do @(posedge clock); while (!req_ready);
      points_sent = points_sent + 1;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CNT_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic build_eye(input int b, input int cx, input int cy, input int w,
                            input int h);
      fx[b]     = cx - w;      fy[b]     = cy;
      fx[b + 3] = cx + w;      fy[b + 3] = cy;
      fx[b + 1] = cx - w / 2;  fy[b + 1] = cy - h;
      fx[b + 2] = cx + w / 2;  fy[b + 2] = cy - h;
      fx[b + 4] = cx + w / 2;  fy[b + 4] = cy + h;
      fx[b + 5] = cx - w / 2;  fy[b + 5] = cy + h;
   endtask

   task automatic build_face(input int closed_pct, input int away_pct);
      int ox, oy, fw, fh, w, h, ex;
      if ($urandom_range(0, 9) == 0) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            fx[i] = $urandom_range(0, 4095) - 2048;
            fy[i] = $urandom_range(0, 4095) - 2048;
         end
         return;
      end
      ox = $urandom_range(0, 1600) - 800;
      oy = $urandom_range(0, 1600) - 800;
      fw = $urandom_range(40, 400);
      fh = $urandom_range(40, 400);
      ex = ($urandom_range(0, 99) < away_pct) ? $urandom_range(fw / 2, fw)
                                              : $urandom_range(0, fw / 2 - 1);
      for (int e = 0; e < 2; e++) begin
         w = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 120);
         h = ($urandom_range(0, 99) < closed_pct) ? $urandom_range(0, w / 6)
                                                  : $urandom_range(0, w + 20);
         build_eye(6 * e, ox + (e ? ex : -ex), oy - $urandom_range(0, fh / 5), w, h);
      end
      fx[12] = ox - fw;  fy[12] = oy;
      fx[13] = ox + fw;  fy[13] = oy;
      fx[14] = ox + $urandom_range(0, 6) - 3;  fy[14] = oy;
      fx[15] = ox;  fy[15] = oy - fh;
      fx[16] = ox;  fy[16] = oy + fh;
   endtask

   task automatic send_face();
      int r;
      r = $urandom_range(0, 99);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_point($urandom_range(NUM_SLOTS, 31), $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
         if (r < 12 && i != NUM_SLOTS - 1 && $urandom_range(0, 1) == 0) continue;
         send_point(i, fx[i], fy[i]);
      end
   endtask

   int thr_set [NUM_PHASES]   = '{255, 0, 128, 64, 200, 100, 255, 80};
   int alert_set [NUM_PHASES] = '{1, 1023, 0, 3, 2, 5, 1, 4};
   int warn_set [NUM_PHASES]  = '{0, 1023, 0, 1, 1, 2, 1023, 0};
   int rec_set [NUM_PHASES]   = '{1, 1023, 0, 5, 3, 1023, 2, 7};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, zero eye width, ignored slots, then a one-point face
      for (int i = 0; i < NUM_SLOTS; i++) begin
         fx[i] = (i % 2) ? 2047 : -2048;
         fy[i] = (i % 3) ? -2048 : 2047;
      end
      fx[3] = fx[0];  fy[3] = fy[0];
      for (int i = 0; i < NUM_SLOTS; i++) send_point(i, fx[i], fy[i]);
      send_point(17, 0, 0);
      send_point(31, 4095, 4095);
      send_point(16, 0, 1);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(REG_EAR_THRESHOLD, thr_set[p]);
         write_reg(REG_ALERT_FRAMES, alert_set[p]);
         write_reg(REG_WARN_FRAMES, warn_set[p]);
         write_reg(REG_RECORD_LENGTH, rec_set[p]);
         quiet = (p % 3 == 1);
         for (int f = 0; f < FACES_PHASE; f++) begin
            build_face($urandom_range(0, 100), $urandom_range(0, 100));
            send_face();
         end
         drain();
      end

      $display("Sent %0d points over %0d setting phases; %0d faces checked, %0d with alerts.",
               points_sent, NUM_PHASES, faces_seen, alerts_seen);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/erdm_pkg.sv
rtl/erdm_front.sv
rtl/erdm_isqrt.sv
rtl/erdm_div.sv
rtl/erdm_back.sv
rtl/eye_ratio_drowsiness_monitor.sv
bench/erdm_checker.sv
bench/tb_eye_ratio_drowsiness_monitor.sv
